/* hw/rtl/fbts_pkg.sv */
package fbts_pkg;

   localparam int MAX_FACES    = 5;
   localparam int SMOOTH_DEPTH = 3;
   localparam int COORD_BITS   = 11;

   localparam int BOX_W      = 11;
   localparam int SCALE_W    = 16;
   localparam int MCOUNT_W   = 5;
   localparam int MOFFSET_W  = 4;
   localparam int SLOT_W     = 4;
   localparam int MASK_W     = 4;
   localparam int SCREEN_W   = 12;
   localparam int FRAC_W     = 8;
   localparam int NUM_COORDS = 4;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_X     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_Y     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MASK_COUNT  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MASK_OFFSET = 2'd3;

   localparam logic [SCALE_W-1:0]   SCALE_RESET   = 16'd768;
   localparam logic [MCOUNT_W-1:0]  MCOUNT_RESET  = 5'd1;
   localparam logic [MCOUNT_W-1:0]  MCOUNT_LIMIT  = 5'd16;
   localparam logic [MOFFSET_W-1:0] MOFFSET_RESET = 4'd0;
   localparam logic [SCREEN_W-1:0]  SCREEN_MAX    = {SCREEN_W{1'b1}};

   localparam int BOX_X = 0;
   localparam int BOX_Y = 1;
   localparam int BOX_WD = 2;
   localparam int BOX_HT = 3;

   localparam int SLOT_CNT_W = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
   localparam int POS_W      = (SMOOTH_DEPTH > 1) ? $clog2(SMOOTH_DEPTH) : 1;

   // exact divide by the window depth: sum * RECIP >> DIV_S
   localparam int DIV_L   = $clog2(SMOOTH_DEPTH);
   localparam int SUM_W   = COORD_BITS + DIV_L;
   localparam int DIV_S   = SUM_W + DIV_L;
   localparam int RECIP_W = DIV_S + 1;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((2 ** DIV_S + SMOOTH_DEPTH - 1) / SMOOTH_DEPTH);

   localparam int MUL1_W = SUM_W + RECIP_W;
   localparam int MUL2_W = COORD_BITS + SCALE_W;
   localparam int SC_W   = MUL2_W - FRAC_W;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef coord_type [NUM_COORDS-1:0] box_type;
   typedef logic [SCREEN_W-1:0] screen_type;
   typedef screen_type [NUM_COORDS-1:0] screen_box_type;

   typedef struct packed {
      logic                  en;
      logic                  present;
      logic [SLOT_CNT_W-1:0] slot;
      box_type               box;
   } lane_wr_type;

   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

   function automatic coord_type to_coord(input logic [BOX_W-1:0] value);
      logic [BOX_W+COORD_BITS-1:0] wide;
      wide = {{COORD_BITS{1'b0}}, value};
      return wide[COORD_BITS-1:0];
   endfunction

endpackage

/* hw/rtl/fbts_if.sv */
interface fbts_req_if;
   logic                        valid;
   logic                        ready;
   logic                        present;
   logic [fbts_pkg::BOX_W-1:0]  box_x;
   logic [fbts_pkg::BOX_W-1:0]  box_y;
   logic [fbts_pkg::BOX_W-1:0]  box_w;
   logic [fbts_pkg::BOX_W-1:0]  box_h;

   modport source (output valid, present, box_x, box_y, box_w, box_h, input ready);
   modport sink (input valid, present, box_x, box_y, box_w, box_h, output ready);
endinterface

interface fbts_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [fbts_pkg::SLOT_W-1:0]    face_slot;
   logic                           shown;
   logic [fbts_pkg::MASK_W-1:0]    mask_index;
   logic [fbts_pkg::SCREEN_W-1:0]  screen_x;
   logic [fbts_pkg::SCREEN_W-1:0]  screen_y;
   logic [fbts_pkg::SCREEN_W-1:0]  screen_w;
   logic [fbts_pkg::SCREEN_W-1:0]  screen_h;

   modport source (output valid, face_slot, shown, mask_index, screen_x, screen_y,
                   screen_w, screen_h, input ready);
   modport sink (input valid, face_slot, shown, mask_index, screen_x, screen_y,
                 screen_w, screen_h, output ready);
endinterface

/* hw/rtl/fbts_lane.sv */
module fbts_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  fbts_pkg::lane_wr_type wr,
   input  logic                  rd_en,
   output fbts_pkg::box_type     rd_data,
   output logic                  hit_valid
);

   fbts_pkg::box_type                mem_ff [fbts_pkg::MAX_FACES];
   fbts_pkg::box_type                rd_data_ff;
   logic [fbts_pkg::MAX_FACES-1:0]   valid_ff;

   // one window position for every slot
   always_ff @(posedge clock) begin
      if (wr.en && wr.present) begin
         mem_ff[wr.slot] <= wr.box;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[wr.slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.slot] <= wr.present;
      end
   end

   assign hit_valid = valid_ff[wr.slot];
   assign rd_data   = rd_data_ff;

endmodule

/* hw/rtl/fbts_merge.sv */
module fbts_merge (
   input  logic                            clock,
   input  fbts_pkg::stage_en_type          en,
   input  fbts_pkg::box_type               lane_val [fbts_pkg::SMOOTH_DEPTH],
   input  logic [fbts_pkg::SCALE_W-1:0]    scale_x,
   input  logic [fbts_pkg::SCALE_W-1:0]    scale_y,
   output fbts_pkg::screen_box_type        screen
);

   logic [fbts_pkg::SUM_W-1:0]   sum_in [fbts_pkg::NUM_COORDS];
   logic [fbts_pkg::SUM_W-1:0]   sum_ff [fbts_pkg::NUM_COORDS];
   logic [fbts_pkg::MUL1_W-1:0]  p1 [fbts_pkg::NUM_COORDS];
   fbts_pkg::box_type            avg_in;
   fbts_pkg::box_type            avg_ff;
   logic [fbts_pkg::MUL2_W-1:0]  p2 [fbts_pkg::NUM_COORDS];
   logic [fbts_pkg::SC_W-1:0]    sc [fbts_pkg::NUM_COORDS];
   fbts_pkg::screen_box_type     scr_in;
   fbts_pkg::screen_box_type     scr_ff;

   // sum across the window lanes
   always_comb begin
      for (int k = 0; k < fbts_pkg::NUM_COORDS; k++) begin
         sum_in[k] = '0;
         for (int i = 0; i < fbts_pkg::SMOOTH_DEPTH; i++) begin
            sum_in[k] = sum_in[k] + fbts_pkg::SUM_W'(lane_val[i][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         sum_ff <= sum_in;
      end
   end

   // truncating average by reciprocal multiply
   always_comb begin
      for (int k = 0; k < fbts_pkg::NUM_COORDS; k++) begin
         p1[k] = fbts_pkg::MUL1_W'(sum_ff[k]) * fbts_pkg::MUL1_W'(fbts_pkg::RECIP);
         avg_in[k] = p1[k][fbts_pkg::DIV_S +: fbts_pkg::COORD_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         avg_ff <= avg_in;
      end
   end

   // q8.8 scale and saturate
   always_comb begin
      for (int k = 0; k < fbts_pkg::NUM_COORDS; k++) begin
         if (k == fbts_pkg::BOX_X || k == fbts_pkg::BOX_WD) begin
            p2[k] = fbts_pkg::MUL2_W'(avg_ff[k]) * fbts_pkg::MUL2_W'(scale_x);
         end else begin
            p2[k] = fbts_pkg::MUL2_W'(avg_ff[k]) * fbts_pkg::MUL2_W'(scale_y);
         end
         sc[k] = p2[k][fbts_pkg::MUL2_W-1:fbts_pkg::FRAC_W];
         if (sc[k] > fbts_pkg::SC_W'(fbts_pkg::SCREEN_MAX)) begin
            scr_in[k] = fbts_pkg::SCREEN_MAX;
         end else begin
            scr_in[k] = sc[k][fbts_pkg::SCREEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         scr_ff <= scr_in;
      end
   end

   assign screen = scr_ff;

endmodule

/* hw/rtl/face_box_temporal_smoother_unit.sv */
// Face box smoother. Each transfer on req_bus is one face slot, slots 0 to MAX_FACES-1 in
// order make a frame; each gives one transfer on rsp_bus with the box averaged over the
// last SMOOTH_DEPTH frames and scaled to screen coordinates, or zeros when any frame of
// the window had no face. One item is taken every cycle unless a stall on rsp_bus holds
// the pipeline: each window position is a lane memory with one write and one read per
// cycle, and the merge pipeline (lane sum, divide, scale) has a register after every stage.
// A stall on rsp_bus only holds the stages that are full. The window valid bits clear at
// reset, so no clearing pass is needed. Configuration writes go through csr_we, csr_index and csr_wdata.
module face_box_temporal_smoother_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   fbts_req_if.sink                             req_bus,
   fbts_rsp_if.source                           rsp_bus,
   input  logic                                 csr_we,
   input  logic [fbts_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fbts_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic [fbts_pkg::SCALE_W-1:0]    scale_x_ff;
   logic [fbts_pkg::SCALE_W-1:0]    scale_y_ff;
   logic [fbts_pkg::MCOUNT_W-1:0]   mask_count_ff;
   logic [fbts_pkg::MOFFSET_W-1:0]  mask_offset_ff;

   logic [fbts_pkg::SLOT_CNT_W-1:0] slot_ff;
   logic [fbts_pkg::POS_W-1:0]      pos_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic ready1, ready2, ready3, ready4;
   logic accept;

   fbts_pkg::lane_wr_type           lane_wr [fbts_pkg::SMOOTH_DEPTH];
   fbts_pkg::box_type               lane_rd [fbts_pkg::SMOOTH_DEPTH];
   logic [fbts_pkg::SMOOTH_DEPTH-1:0] lane_hit;
   fbts_pkg::box_type               lane_val [fbts_pkg::SMOOTH_DEPTH];

   fbts_pkg::box_type               box_in;
   logic                            show_in;

   fbts_pkg::box_type               box1_ff;
   logic [fbts_pkg::POS_W-1:0]      pos1_ff;
   logic [fbts_pkg::SLOT_CNT_W-1:0] slot1_ff, slot2_ff, slot3_ff, slot4_ff;
   logic                            show1_ff, show2_ff, show3_ff, show4_ff;
   logic [fbts_pkg::MASK_W-1:0]     mask_in, mask2_ff, mask3_ff, mask4_ff;

   logic [fbts_pkg::MCOUNT_W-1:0]   mc;
   logic [2*fbts_pkg::MCOUNT_W-1:0] rem;
   logic [2*fbts_pkg::MCOUNT_W-1:0] dv;

   fbts_pkg::stage_en_type          stage_en;
   fbts_pkg::screen_box_type        screen;

   // stage handshake
   assign ready4 = !v4_ff || rsp_bus.ready;
   assign ready3 = !v3_ff || ready4;
   assign ready2 = !v2_ff || ready3;
   assign ready1 = !v1_ff || ready2;
   assign req_bus.ready = ready1;
   assign accept = req_bus.valid && ready1;

   assign stage_en.s2 = ready2;
   assign stage_en.s3 = ready3;
   assign stage_en.s4 = ready4;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff     <= fbts_pkg::SCALE_RESET;
         scale_y_ff     <= fbts_pkg::SCALE_RESET;
         mask_count_ff  <= fbts_pkg::MCOUNT_RESET;
         mask_offset_ff <= fbts_pkg::MOFFSET_RESET;
      end else if (csr_we) begin
         case (csr_index)
            fbts_pkg::CSR_SCALE_X: begin
               scale_x_ff <= csr_wdata[fbts_pkg::SCALE_W-1:0];
            end
            fbts_pkg::CSR_SCALE_Y: begin
               scale_y_ff <= csr_wdata[fbts_pkg::SCALE_W-1:0];
            end
            fbts_pkg::CSR_MASK_COUNT: begin
               mask_count_ff <= csr_wdata[fbts_pkg::MCOUNT_W-1:0];
            end
            fbts_pkg::CSR_MASK_OFFSET: begin
               mask_offset_ff <= csr_wdata[fbts_pkg::MOFFSET_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // slot and window position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         pos_ff  <= '0;
      end else if (accept) begin
         if (slot_ff == fbts_pkg::SLOT_CNT_W'(fbts_pkg::MAX_FACES - 1)) begin
            slot_ff <= '0;
            if (pos_ff == fbts_pkg::POS_W'(fbts_pkg::SMOOTH_DEPTH - 1)) begin
               pos_ff <= '0;
            end else begin
               pos_ff <= pos_ff + 1'b1;
            end
         end else begin
            slot_ff <= slot_ff + 1'b1;
         end
      end
   end

   always_comb begin
      box_in[fbts_pkg::BOX_X]  = fbts_pkg::to_coord(req_bus.box_x);
      box_in[fbts_pkg::BOX_Y]  = fbts_pkg::to_coord(req_bus.box_y);
      box_in[fbts_pkg::BOX_WD] = fbts_pkg::to_coord(req_bus.box_w);
      box_in[fbts_pkg::BOX_HT] = fbts_pkg::to_coord(req_bus.box_h);
   end

   // window lanes
   for (genvar i = 0; i < fbts_pkg::SMOOTH_DEPTH; i++) begin : g_lane
      assign lane_wr[i].en      = accept && (pos_ff == fbts_pkg::POS_W'(i));
      assign lane_wr[i].present = req_bus.present;
      assign lane_wr[i].slot    = slot_ff;
      assign lane_wr[i].box     = box_in;

      fbts_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .wr        (lane_wr[i]),
         .rd_en     (ready1),
         .rd_data   (lane_rd[i]),
         .hit_valid (lane_hit[i])
      );
   end

   // whole window valid, with this transfer in its position
   always_comb begin
      show_in = 1'b1;
      for (int i = 0; i < fbts_pkg::SMOOTH_DEPTH; i++) begin
         if (pos_ff == fbts_pkg::POS_W'(i)) begin
            show_in = show_in & req_bus.present;
         end else begin
            show_in = show_in & lane_hit[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         box1_ff  <= box_in;
         pos1_ff  <= pos_ff;
         slot1_ff <= slot_ff;
         show1_ff <= show_in;
      end
   end

   // new sample bypasses the lane read
   always_comb begin
      for (int i = 0; i < fbts_pkg::SMOOTH_DEPTH; i++) begin
         if (pos1_ff == fbts_pkg::POS_W'(i)) begin
            lane_val[i] = box1_ff;
         end else begin
            lane_val[i] = lane_rd[i];
         end
      end
   end

   // mask index remainder by shift and subtract
   always_comb begin
      mc = mask_count_ff;
      if (mc == '0) begin
         mc = fbts_pkg::MCOUNT_RESET;
      end else if (mc > fbts_pkg::MCOUNT_LIMIT) begin
         mc = fbts_pkg::MCOUNT_LIMIT;
      end
      rem = (2*fbts_pkg::MCOUNT_W)'(mask_offset_ff) + (2*fbts_pkg::MCOUNT_W)'(slot1_ff);
      dv  = '0;
      for (int b = fbts_pkg::MCOUNT_W - 1; b >= 0; b--) begin
         dv = (2*fbts_pkg::MCOUNT_W)'(mc) << b;
         if (rem >= dv) begin
            rem = rem - dv;
         end
      end
      mask_in = rem[fbts_pkg::MASK_W-1:0];
   end

   fbts_merge u_merge (
      .clock    (clock),
      .en       (stage_en),
      .lane_val (lane_val),
      .scale_x  (scale_x_ff),
      .scale_y  (scale_y_ff),
      .screen   (screen)
   );

   always_ff @(posedge clock) begin
      if (ready2) begin
         slot2_ff <= slot1_ff;
         show2_ff <= show1_ff;
         mask2_ff <= mask_in;
      end
      if (ready3) begin
         slot3_ff <= slot2_ff;
         show3_ff <= show2_ff;
         mask3_ff <= mask2_ff;
      end
      if (ready4) begin
         slot4_ff <= slot3_ff;
         show4_ff <= show3_ff;
         mask4_ff <= mask3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (ready1) begin
            v1_ff <= accept;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
         if (ready3) begin
            v3_ff <= v2_ff;
         end
         if (ready4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   assign rsp_bus.valid      = v4_ff;
   assign rsp_bus.face_slot  = fbts_pkg::SLOT_W'(slot4_ff);
   assign rsp_bus.shown      = show4_ff;
   assign rsp_bus.mask_index = mask4_ff;
   assign rsp_bus.screen_x   = show4_ff ? screen[fbts_pkg::BOX_X]  : '0;
   assign rsp_bus.screen_y   = show4_ff ? screen[fbts_pkg::BOX_Y]  : '0;
   assign rsp_bus.screen_w   = show4_ff ? screen[fbts_pkg::BOX_WD] : '0;
   assign rsp_bus.screen_h   = show4_ff ? screen[fbts_pkg::BOX_HT] : '0;

endmodule

/* test/tb_face_box_temporal_smoother_unit.sv */
`timescale 1ns / 1ps

module tb_face_box_temporal_smoother_unit;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_PHASES = 7;
   localparam int ITEMS_PER_PHASE = 100;

   typedef struct packed {
      logic                       present;
      logic [fbts_pkg::BOX_W-1:0] box_x;
      logic [fbts_pkg::BOX_W-1:0] box_y;
      logic [fbts_pkg::BOX_W-1:0] box_w;
      logic [fbts_pkg::BOX_W-1:0] box_h;
   } face_item_type;

   typedef struct packed {
      logic [fbts_pkg::SLOT_W-1:0] slot;
      logic                        shown;
      logic [fbts_pkg::MASK_W-1:0] mask;
      fbts_pkg::screen_box_type    scr;
   } face_result_type;

   logic clock = 1'b0;
   logic reset;
   logic                             csr_we;
   logic [fbts_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [fbts_pkg::CSR_DATA_W-1:0]  csr_wdata;

   fbts_req_if req_bus ();
   fbts_rsp_if rsp_bus ();

   face_box_temporal_smoother_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // smoother state as predicted
   logic [fbts_pkg::SCALE_W-1:0]   cfg_scale_x;
   logic [fbts_pkg::SCALE_W-1:0]   cfg_scale_y;
   logic [fbts_pkg::MCOUNT_W-1:0]  cfg_mask_count;
   logic [fbts_pkg::MOFFSET_W-1:0] cfg_mask_offset;
   fbts_pkg::box_type ring_box [fbts_pkg::MAX_FACES][fbts_pkg::SMOOTH_DEPTH];
   bit                ring_ok [fbts_pkg::MAX_FACES][fbts_pkg::SMOOTH_DEPTH];
   int unsigned slot_next;
   int unsigned ring_pos;

   face_item_type   pending_faces[$];
   face_result_type expected_boxes[$];
   face_item_type   face_on_bus;
   face_result_type got_box;
   face_result_type want_box;

   int sender_idle_pct;
   int receiver_idle_pct;
   int errors;
   int faces_sent;
   int shown_seen;
   int hidden_seen;
   int settings_used;

   function automatic fbts_pkg::screen_type scale_clip(
         input int unsigned avg, input logic [fbts_pkg::SCALE_W-1:0] scale);
      longint unsigned v;
      v = (longint'(avg) * longint'(scale)) >> fbts_pkg::FRAC_W;
      return (v > fbts_pkg::SCREEN_MAX) ? fbts_pkg::SCREEN_MAX : fbts_pkg::screen_type'(v);
   endfunction

   function automatic face_result_type smooth_face(input face_item_type f);
      face_result_type r;
      int unsigned     sum [fbts_pkg::NUM_COORDS];
      int unsigned     filled;
      int unsigned     mc;
      int unsigned     slot;
      int unsigned     pos;
      slot = slot_next;
      pos = ring_pos;
      if (f.present) begin
         ring_box[slot][pos][fbts_pkg::BOX_X] = f.box_x;
         ring_box[slot][pos][fbts_pkg::BOX_Y] = f.box_y;
         ring_box[slot][pos][fbts_pkg::BOX_WD] = f.box_w;
         ring_box[slot][pos][fbts_pkg::BOX_HT] = f.box_h;
      end
      ring_ok[slot][pos] = f.present;
      filled = 0;
      for (int k = 0; k < fbts_pkg::NUM_COORDS; k++) sum[k] = 0;
      for (int i = 0; i < fbts_pkg::SMOOTH_DEPTH; i++) begin
         if (ring_ok[slot][i]) begin
            filled++;
            for (int k = 0; k < fbts_pkg::NUM_COORDS; k++) sum[k] += ring_box[slot][i][k];
         end
      end
      mc = cfg_mask_count;
      if (mc == 0) mc = 1;
      if (mc > fbts_pkg::MCOUNT_LIMIT) mc = fbts_pkg::MCOUNT_LIMIT;
      r.slot = fbts_pkg::SLOT_W'(slot);
      r.shown = (filled == fbts_pkg::SMOOTH_DEPTH);
      r.mask = fbts_pkg::MASK_W'((cfg_mask_offset + slot) % mc);
      r.scr = '0;
      if (r.shown) begin
         r.scr[fbts_pkg::BOX_X] =
            scale_clip(sum[fbts_pkg::BOX_X] / fbts_pkg::SMOOTH_DEPTH, cfg_scale_x);
         r.scr[fbts_pkg::BOX_Y] =
            scale_clip(sum[fbts_pkg::BOX_Y] / fbts_pkg::SMOOTH_DEPTH, cfg_scale_y);
         r.scr[fbts_pkg::BOX_WD] =
            scale_clip(sum[fbts_pkg::BOX_WD] / fbts_pkg::SMOOTH_DEPTH, cfg_scale_x);
         r.scr[fbts_pkg::BOX_HT] =
            scale_clip(sum[fbts_pkg::BOX_HT] / fbts_pkg::SMOOTH_DEPTH, cfg_scale_y);
      end
      if (slot + 1 >= fbts_pkg::MAX_FACES) begin
         slot_next = 0;
         ring_pos = (pos + 1) % fbts_pkg::SMOOTH_DEPTH;
      end else begin
         slot_next = slot + 1;
      end
      return r;
   endfunction

   function automatic face_item_type make_face(input logic p, input int x, input int y,
                                               input int w, input int h);
      face_item_type f;
      f.present = p;
      f.box_x = fbts_pkg::BOX_W'(x);
      f.box_y = fbts_pkg::BOX_W'(y);
      f.box_w = fbts_pkg::BOX_W'(w);
      f.box_h = fbts_pkg::BOX_W'(h);
      return f;
   endfunction

   function automatic face_item_type random_face();
      face_item_type f;
      int unsigned   kind;
      kind = $urandom_range(99);
      f = make_face(kind >= 8, $urandom_range(2047), $urandom_range(2047),
                    $urandom_range(2047), $urandom_range(2047));
      // corner boxes: each coordinate at zero or full scale
      if (kind >= 8 && kind < 16) begin
         f.box_x = $urandom_range(1) ? '1 : '0;
         f.box_y = $urandom_range(1) ? '1 : '0;
         f.box_w = $urandom_range(1) ? '1 : '0;
         f.box_h = $urandom_range(1) ? '1 : '0;
      end
      return f;
   endfunction

   task automatic write_reg(input logic [fbts_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [fbts_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         fbts_pkg::CSR_SCALE_X: cfg_scale_x = val;
         fbts_pkg::CSR_SCALE_Y: cfg_scale_y = val;
         fbts_pkg::CSR_MASK_COUNT: cfg_mask_count = val[fbts_pkg::MCOUNT_W-1:0];
         fbts_pkg::CSR_MASK_OFFSET: cfg_mask_offset = val[fbts_pkg::MOFFSET_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_regs(input int sx, input int sy, input int mc, input int off);
      write_reg(fbts_pkg::CSR_SCALE_X, fbts_pkg::CSR_DATA_W'(sx));
      write_reg(fbts_pkg::CSR_SCALE_Y, fbts_pkg::CSR_DATA_W'(sy));
      write_reg(fbts_pkg::CSR_MASK_COUNT, fbts_pkg::CSR_DATA_W'(mc));
      write_reg(fbts_pkg::CSR_MASK_OFFSET, fbts_pkg::CSR_DATA_W'(off));
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic wait_drained();
      while (pending_faces.size() != 0 || req_bus.valid === 1'b1 ||
             expected_boxes.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.present <= 1'b0;
         req_bus.box_x <= '0;
         req_bus.box_y <= '0;
         req_bus.box_w <= '0;
         req_bus.box_h <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_boxes.push_back(smooth_face(face_on_bus));
            faces_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_faces.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               face_on_bus = pending_faces.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.present <= face_on_bus.present;
               req_bus.box_x <= face_on_bus.box_x;
               req_bus.box_y <= face_on_bus.box_y;
               req_bus.box_w <= face_on_bus.box_w;
               req_bus.box_h <= face_on_bus.box_h;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_box.slot = rsp_bus.face_slot;
            got_box.shown = rsp_bus.shown;
            got_box.mask = rsp_bus.mask_index;
            got_box.scr[fbts_pkg::BOX_X] = rsp_bus.screen_x;
            got_box.scr[fbts_pkg::BOX_Y] = rsp_bus.screen_y;
            got_box.scr[fbts_pkg::BOX_WD] = rsp_bus.screen_w;
            got_box.scr[fbts_pkg::BOX_HT] = rsp_bus.screen_h;
            if (expected_boxes.size() == 0) begin
               errors++;
               $display("%0t: unexpected transfer, expected none, actual slot %0d shown %0d",
                        $time, got_box.slot, got_box.shown);
            end else begin
               want_box = expected_boxes.pop_front();
               if (got_box !== want_box) begin
                  errors++;
                  $display("%0t: mismatch expected slot %0d shown %0d mask %0d box %0d %0d %0d %0d",
                           $time, want_box.slot, want_box.shown, want_box.mask,
                           want_box.scr[fbts_pkg::BOX_X], want_box.scr[fbts_pkg::BOX_Y],
                           want_box.scr[fbts_pkg::BOX_WD], want_box.scr[fbts_pkg::BOX_HT]);
                  $display("%0t:          actual slot %0d shown %0d mask %0d box %0d %0d %0d %0d",
                           $time, got_box.slot, got_box.shown, got_box.mask,
                           got_box.scr[fbts_pkg::BOX_X], got_box.scr[fbts_pkg::BOX_Y],
                           got_box.scr[fbts_pkg::BOX_WD], got_box.scr[fbts_pkg::BOX_HT]);
               end
               if (want_box.shown) shown_seen++;
               else hidden_seen++;
            end
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      cfg_scale_x = fbts_pkg::SCALE_RESET;
      cfg_scale_y = fbts_pkg::SCALE_RESET;
      cfg_mask_count = fbts_pkg::MCOUNT_RESET;
      cfg_mask_offset = fbts_pkg::MOFFSET_RESET;
      for (int s = 0; s < fbts_pkg::MAX_FACES; s++) begin
         for (int i = 0; i < fbts_pkg::SMOOTH_DEPTH; i++) begin
            ring_box[s][i] = '0;
            ring_ok[s][i] = 1'b0;
         end
      end
      slot_next = 0;
      ring_pos = 0;
      errors = 0;
      faces_sent = 0;
      shown_seen = 0;
      hidden_seen = 0;
      settings_used = 1;
      sender_idle_pct = 22;
      receiver_idle_pct = 54;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // three full frames under reset settings: zero, full scale, exact limit, truncation
      for (int f = 0; f < 3; f++) begin
         pending_faces.push_back(make_face(1'b1, 0, 0, 0, 0));
         pending_faces.push_back(make_face(1'b1, 2047, 2047, 2047, 2047));
         pending_faces.push_back(make_face(1'b1, 2047, 0, 1365, 682));
         pending_faces.push_back(make_face(1'b1, (f == 2) ? 1002 : 1000, 1, 2, 3));
         pending_faces.push_back(random_face());
      end
      wait_drained();

      // absent faces break the window; widest scale, unity scale, zero mask count
      program_regs(65535, 256, 0, 15);
      for (int s = 0; s < fbts_pkg::MAX_FACES; s++) begin
         pending_faces.push_back(make_face(s % 2 == 1, 2047, 2047, 2047, 2047));
      end
      for (int s = 0; s < fbts_pkg::MAX_FACES; s++) pending_faces.push_back(random_face());
      wait_drained();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 2) begin
            sender_idle_pct = 54;
            receiver_idle_pct = 22;
         end else if (p == 4) begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         case (p)
            0: program_regs(256, 256, 16, 15);
            1: program_regs(0, 65535, 31, 7);
            2: program_regs(65535, 1, 5, 9);
            3: program_regs(768, 512, 1, 0);
            default: program_regs($urandom_range(65535), $urandom_range(65535),
                                  $urandom_range(65535), $urandom_range(65535));
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) pending_faces.push_back(random_face());
         wait_drained();
      end

      $display("covered %0d face transfers over %0d register settings", faces_sent,
               settings_used);
      $display("boxes shown %0d, hidden %0d, mismatches %0d", shown_seen, hidden_seen,
               errors);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* face_box_temporal_smoother_unit.f */
hw/rtl/fbts_pkg.sv
hw/rtl/fbts_if.sv
hw/rtl/fbts_lane.sv
hw/rtl/fbts_merge.sv
hw/rtl/face_box_temporal_smoother_unit.sv
test/tb_face_box_temporal_smoother_unit.sv
